/* hw/rtl/npcm_pkg.sv */
// Package for the nearest palette color match block: state type and shared constants.
`timescale 1ns / 1ps

package npcm_pkg;

    // Request kinds carried on s_tuser
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_MATCH = 2'd1;
    localparam logic [1:0] FUNC_SHADE = 2'd2;

    // Register reset and shading arithmetic
    localparam logic [8:0] FULLBRIGHT_RESET = 9'd32;
    localparam logic [4:0] ROUND_ADD        = 5'd16;
    localparam int         ROUND_SHIFT      = 5;
    localparam logic [7:0] COMPONENT_MAX    = 8'd255;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHADE_RD,
        ST_SHADE_MUL,
        ST_SEARCH,
        ST_WAIT_OUT
    } npcm_state_t;

endpackage

/* hw/rtl/nearest_palette_color_match_top.sv */
// Top level of the nearest palette color match block: palette memory, search and shading.
`timescale 1ns / 1ps

// Nearest palette color match.
// Input words arrive on s_tvalid/s_tready/s_tdata with the request kind on s_tuser:
//   write   - stores one palette entry and gives no result word.
//   match   - scans every palette entry for the least squared RGB distance
//             (lowest index wins a tie) and returns index and distance.
//   shade   - scales one palette entry by the light row, then matches it; an entry in
//             the fullbright range returns its own index with distance 0.
// Results leave on m_tvalid/m_tready/m_tdata. One memory read port is walked one entry
// per cycle through a three-stage read / square / compare pipe. The block takes one
// word at a time; it is ready again once the result has moved into the output register,
// so the next word may be taken while it waits.
// A stalled receiver holds the result in the output register; a second finished result
// waits inside the block until the output register frees.
// Reset (aresetn low, synchronous) returns to idle, drops m_tvalid and sets
// fullbright_count to 32. Palette contents are undefined until written.
// cfg_we/cfg_wdata write fullbright_count; write it only while the block is idle.
module nearest_palette_color_match_top #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int SHADE_LEVELS    = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Config register fullbright_count
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // entry_index[7:0], red[15:8], green[23:16],
                                   // blue[31:24], shade_level[37:32], zero[39:38]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // best_index[7:0], best_distance[25:8], zero[31:26]
);

    import npcm_pkg::*;

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CW = $clog2(PALETTE_ENTRIES + 1);
    localparam logic [8:0]    PE_9      = 9'(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);
    localparam logic [5:0]    MAX_LEVEL = 6'(SHADE_LEVELS - 1);

    // Input field unpack
    logic [7:0] in_index;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [5:0] in_level;
    assign in_index = s_tdata[7:0];
    assign in_red   = s_tdata[15:8];
    assign in_green = s_tdata[23:16];
    assign in_blue  = s_tdata[31:24];
    assign in_level = s_tdata[37:32];

    npcm_state_t state_reg, state_next;

    logic [8:0]    fullbright_reg;
    logic [23:0]   palette_mem [PALETTE_ENTRIES];
    logic [23:0]   rd_data_reg;

    logic [7:0]    item_index_reg;
    logic [5:0]    item_scale_reg;
    logic [7:0]    tgt_r_reg, tgt_g_reg, tgt_b_reg;

    logic [CW-1:0] issue_cnt_reg;
    logic          v1_reg, v2_reg;
    logic [AW-1:0] idx1_reg, idx2_reg;
    logic [15:0]   sq_r_reg, sq_g_reg, sq_b_reg;

    logic          found_reg;
    logic [AW-1:0] best_idx_reg;
    logic [17:0]   best_dist_reg;

    logic          m_tvalid_reg;
    logic [31:0]   m_tdata_reg;

    // Decode of the incoming word
    logic          accept;
    logic          wr_in_range;
    logic [8:0]    fb_sat;
    logic          is_fullbright;
    logic [5:0]    level_sat;
    assign accept        = s_tvalid && s_tready;
    assign wr_in_range   = {1'b0, in_index} < PE_9;
    assign fb_sat        = (fullbright_reg > PE_9) ? PE_9 : fullbright_reg;
    assign is_fullbright = {1'b0, in_index} >= (PE_9 - fb_sat);
    assign level_sat     = (in_level > MAX_LEVEL) ? MAX_LEVEL : in_level;

    // Control outputs of the sequencer
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          issue;
    logic          out_free;
    logic          last_cmp;

    assign out_free = !m_tvalid_reg || m_tready;
    assign last_cmp = v2_reg && (idx2_reg == LAST_ADDR);

    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = issue_cnt_reg[AW-1:0];
        issue    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SHADE_RD: begin
                rd_en   = 1'b1;
                rd_addr = item_index_reg[AW-1:0];
            end
            ST_SEARCH: begin
                issue = issue_cnt_reg < CW'(PALETTE_ENTRIES);
                rd_en = issue;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        FUNC_MATCH: state_next = ST_SEARCH;
                        FUNC_SHADE: state_next = is_fullbright ? ST_WAIT_OUT : ST_SHADE_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SHADE_RD:  state_next = ST_SHADE_MUL;
            ST_SHADE_MUL: state_next = ST_SEARCH;
            ST_SEARCH: begin
                if (last_cmp) state_next = ST_WAIT_OUT;
            end
            ST_WAIT_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fullbright_reg <= FULLBRIGHT_RESET;
        end else if (cfg_we) begin
            fullbright_reg <= cfg_wdata;
        end
    end

    // Palette memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (accept && s_tuser == FUNC_WRITE && wr_in_range) begin
            palette_mem[in_index[AW-1:0]] <= {in_blue, in_green, in_red};
        end
        if (rd_en) begin
            rd_data_reg <= palette_mem[rd_addr];
        end
    end

    // Shading: scale each component, round, clamp
    logic [13:0] prod_r, prod_g, prod_b;
    logic [8:0]  shd_r, shd_g, shd_b;
    assign prod_r = 14'(rd_data_reg[7:0])   * 14'(item_scale_reg);
    assign prod_g = 14'(rd_data_reg[15:8])  * 14'(item_scale_reg);
    assign prod_b = 14'(rd_data_reg[23:16]) * 14'(item_scale_reg);
    assign shd_r  = 9'((prod_r + 14'(ROUND_ADD)) >> ROUND_SHIFT);
    assign shd_g  = 9'((prod_g + 14'(ROUND_ADD)) >> ROUND_SHIFT);
    assign shd_b  = 9'((prod_b + 14'(ROUND_ADD)) >> ROUND_SHIFT);

    // Item registers and search target
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_index_reg <= in_index;
            item_scale_reg <= MAX_LEVEL - level_sat;
            tgt_r_reg      <= in_red;
            tgt_g_reg      <= in_green;
            tgt_b_reg      <= in_blue;
        end else if (state_reg == ST_SHADE_MUL) begin
            tgt_r_reg <= (shd_r > 9'(COMPONENT_MAX)) ? COMPONENT_MAX : shd_r[7:0];
            tgt_g_reg <= (shd_g > 9'(COMPONENT_MAX)) ? COMPONENT_MAX : shd_g[7:0];
            tgt_b_reg <= (shd_b > 9'(COMPONENT_MAX)) ? COMPONENT_MAX : shd_b[7:0];
        end
    end

    // Search pipe stage 2: absolute differences squared
    logic [7:0] d_r, d_g, d_b;
    assign d_r = (rd_data_reg[7:0] > tgt_r_reg) ? rd_data_reg[7:0] - tgt_r_reg
                                                : tgt_r_reg - rd_data_reg[7:0];
    assign d_g = (rd_data_reg[15:8] > tgt_g_reg) ? rd_data_reg[15:8] - tgt_g_reg
                                                 : tgt_g_reg - rd_data_reg[15:8];
    assign d_b = (rd_data_reg[23:16] > tgt_b_reg) ? rd_data_reg[23:16] - tgt_b_reg
                                                  : tgt_b_reg - rd_data_reg[23:16];

    // Stage 3: sum and compare against the running best
    logic [17:0] sum_dist;
    assign sum_dist = 18'(sq_r_reg) + 18'(sq_g_reg) + 18'(sq_b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_cnt_reg <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            if (state_reg != ST_SEARCH) begin
                issue_cnt_reg <= '0;
                found_reg     <= 1'b0;
            end else if (issue) begin
                issue_cnt_reg <= issue_cnt_reg + CW'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (v2_reg) found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg <= issue_cnt_reg[AW-1:0];
        idx2_reg <= idx1_reg;
        sq_r_reg <= 16'(d_r) * 16'(d_r);
        sq_g_reg <= 16'(d_g) * 16'(d_g);
        sq_b_reg <= 16'(d_b) * 16'(d_b);
        if (accept && s_tuser == FUNC_SHADE && is_fullbright) begin
            best_idx_reg  <= in_index[AW-1:0];
            best_dist_reg <= '0;
        end else if (v2_reg && (!found_reg || sum_dist < best_dist_reg)) begin
            best_idx_reg  <= idx2_reg;
            best_dist_reg <= sum_dist;
        end
    end

    // Fullbright answers its own index, which may lie past the palette
    logic [7:0] out_index_reg;
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_index_reg <= in_index;
        end
    end

    // Output register
    logic       out_fb_reg;
    logic [7:0] res_index;
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_fb_reg <= s_tuser == FUNC_SHADE && is_fullbright;
        end
    end
    assign res_index = out_fb_reg ? out_index_reg : 8'(best_idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_WAIT_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WAIT_OUT && out_free) begin
            m_tdata_reg <= {6'd0, best_dist_reg, res_index};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
